// ===== design/sorted_table_key_search_defines.svh =====
// ---------------------------------------------------------------------------
// sorted_table_key_search_defines.svh
// Assertion macros shared by the key search block.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_KEY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_KEY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define STKS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("key search: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define STKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("key search: next-cycle check failed");

`endif

// ===== design/stks_pkg.sv =====
// ---------------------------------------------------------------------------
// stks_pkg
// Types and constants of the sorted table key search block.
// ---------------------------------------------------------------------------
package stks_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 24;
	localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	// Signed probe bounds: bot up to TABLE_DEPTH, top down to -1
	localparam int PTR_BITS    = ADDR_BITS + 2;

	// Fixed field widths of the ports
	localparam int IDX_BITS    = 10;
	localparam int SKEY_BITS   = 24;
	localparam int LAST_BITS   = 10;

	typedef enum logic [0:0] {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} stks_op_t;

	typedef struct packed {
		stks_op_t              opcode;
		logic [IDX_BITS-1:0]   entry_index;
		logic [SKEY_BITS-1:0]  search_key;
	} stks_in_t;

	typedef struct packed {
		logic                  hit;
		logic [IDX_BITS-1:0]   found_index;
	} stks_out_t;

	// Table memory access from the search engine
	typedef struct packed {
		logic                  we;
		logic [ADDR_BITS-1:0]  waddr;
		logic [KEY_BITS-1:0]   wdata;
		logic [ADDR_BITS-1:0]  raddr;
	} stks_ram_req_t;

endpackage

// ===== design/sorted_table_key_search.sv =====
// ---------------------------------------------------------------------------
// sorted_table_key_search
// Key table with binary search lookup and a linear scan on a miss.
//
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    stks_in_t  (write or lookup)
// out       source     out_valid/out_ready  stks_out_t (one per lookup)
// cfg       sink       cfg_we               cfg_wdata  (last_index)
//
// A write goes to the table in the cycle it is accepted. A lookup is accepted,
// then probes the table (about log2(last_index+1)+1 probes), then waits until
// the output register takes the result; a miss adds up to last_index+1 scan probes.
// Lookup time is set by the single read port of the table memory, one probe per cycle.
// The output register holds a result under stall while the next transaction
// is accepted. Reset clears control state and last_index; the table is not
// cleared.
// ---------------------------------------------------------------------------
module sorted_table_key_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  stks_pkg::stks_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output stks_pkg::stks_out_t             out_data,
	input  logic                            cfg_we,
	input  logic [stks_pkg::LAST_BITS-1:0]  cfg_wdata
);

	logic [stks_pkg::LAST_BITS-1:0]  last_index_q;
	stks_pkg::stks_ram_req_t         ram_req;
	logic [stks_pkg::KEY_BITS-1:0]   ram_rdata;
	logic                            res_valid;
	logic                            res_ready;
	stks_pkg::stks_out_t             res;
	logic                            out_valid_q;
	stks_pkg::stks_out_t             out_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= '0;
		end else if (cfg_we) begin
			last_index_q <= cfg_wdata;
		end
	end

	// Key table
	stks_ram #(
		.WIDTH (stks_pkg::KEY_BITS),
		.DEPTH (stks_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Search engine
	stks_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.last_index (last_index_q),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload until the transaction completes
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/stks_ram.sv =====
// ---------------------------------------------------------------------------
// stks_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module stks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/stks_search.sv =====
// ---------------------------------------------------------------------------
// stks_search
// Search engine: table writes, binary search probes, then a linear scan on a miss.
// ---------------------------------------------------------------------------
`include "sorted_table_key_search_defines.svh"

module stks_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  stks_pkg::stks_in_t              in_data,
	input  logic [stks_pkg::LAST_BITS-1:0]  last_index,
	output stks_pkg::stks_ram_req_t         ram_req,
	input  logic [stks_pkg::KEY_BITS-1:0]   ram_rdata,
	output logic                            res_valid,
	input  logic                            res_ready,
	output stks_pkg::stks_out_t             res
);

	localparam int AB = stks_pkg::ADDR_BITS;
	localparam int PB = stks_pkg::PTR_BITS;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BIN  = 4'b0010,
		ST_LIN  = 4'b0100,
		ST_RES  = 4'b1000
	} stks_state_t;

	stks_state_t                     state_q, state_d;
	logic signed [PB-1:0]            bot_q, bot_d;
	logic signed [PB-1:0]            top_q, top_d;
	logic [AB-1:0]                   probe_q, probe_d;
	logic [stks_pkg::KEY_BITS-1:0]   key_q;
	logic                            hit_q, hit_d;
	logic [AB-1:0]                   idx_q, idx_d;
	logic [AB-1:0]                   last_eff;
	logic signed [PB-1:0]            mid_s;
	logic                            match;
	logic                            accept;

	// Midpoint of the signed bounds, clipped to zero and to the last searched entry
	function automatic logic [AB-1:0] calc_mid(
		input logic signed [PB-1:0] bot,
		input logic signed [PB-1:0] top,
		input logic [AB-1:0]        last
	);
		logic signed [PB-1:0] sum;
		logic signed [PB-1:0] half;
		logic signed [PB-1:0] last_s;
		sum    = bot + top;
		half   = (sum >= 0) ? (sum >>> 1) : '0;
		last_s = signed'(PB'(last));
		if (half > last_s) begin
			half = last_s;
		end
		return AB'(half);
	endfunction

	// Clip the configured last index to the table
	assign last_eff = (32'(last_index) > 32'(stks_pkg::TABLE_DEPTH - 1)) ?
		AB'(stks_pkg::TABLE_DEPTH - 1) : AB'(last_index);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign match    = (ram_rdata == key_q);
	assign mid_s    = signed'(PB'(probe_q));

	// Table write port: writes land straight from the input transaction
	always_comb begin
		ram_req.we    = accept && (in_data.opcode == stks_pkg::OP_WRITE) &&
			(32'(in_data.entry_index) < 32'(stks_pkg::TABLE_DEPTH));
		ram_req.waddr = AB'(in_data.entry_index);
		ram_req.wdata = stks_pkg::KEY_BITS'(in_data.search_key);
		ram_req.raddr = probe_d;
	end

	// Next-state logic: one probe per cycle
	always_comb begin
		state_d = state_q;
		bot_d   = bot_q;
		top_d   = top_q;
		probe_d = probe_q;
		hit_d   = hit_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_data.opcode == stks_pkg::OP_LOOKUP)) begin
					bot_d   = '0;
					top_d   = signed'(PB'(last_eff));
					probe_d = calc_mid('0, signed'(PB'(last_eff)), last_eff);
					state_d = ST_BIN;
				end
			end
			ST_BIN: begin
				if (match) begin
					hit_d   = 1'b1;
					idx_d   = probe_q;
					state_d = ST_RES;
				end else if (bot_q >= top_q) begin
					probe_d = '0;
					state_d = ST_LIN;
				end else begin
					if (ram_rdata > key_q) begin
						top_d = mid_s - PB'(1);
					end else begin
						bot_d = mid_s + PB'(1);
					end
					probe_d = calc_mid(bot_d, top_d, last_eff);
				end
			end
			ST_LIN: begin
				if (match) begin
					hit_d   = 1'b1;
					idx_d   = probe_q;
					state_d = ST_RES;
				end else if (probe_q == last_eff) begin
					hit_d   = 1'b0;
					idx_d   = '0;
					state_d = ST_RES;
				end else begin
					probe_d = probe_q + AB'(1);
				end
			end
			ST_RES: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search bounds, probe address and result hold
	always_ff @(posedge clk) begin
		bot_q   <= bot_d;
		top_q   <= top_d;
		probe_q <= probe_d;
		hit_q   <= hit_d;
		idx_q   <= idx_d;
		if (accept) begin
			key_q <= stks_pkg::KEY_BITS'(in_data.search_key);
		end
	end

	assign res_valid       = (state_q == ST_RES);
	assign res.hit         = hit_q;
	assign res.found_index = hit_q ? stks_pkg::IDX_BITS'(idx_q) : '0;

	// A lookup always starts with a binary probe
	`STKS_ASSERT_NEXT(a_lookup_starts_bin, clk, arst_n,
		accept && (in_data.opcode == stks_pkg::OP_LOOKUP), state_q == ST_BIN)
	// Bounds never cross by more than one entry
	`STKS_ASSERT_NOW(a_bounds_order, clk, arst_n,
		state_q == ST_BIN, bot_q <= top_q + PB'(1))
	// Probes stay inside the searched range
	`STKS_ASSERT_NOW(a_probe_in_range, clk, arst_n,
		(state_q == ST_BIN) || (state_q == ST_LIN), probe_q <= last_eff)
	// A reported index lies inside the searched range
	`STKS_ASSERT_NOW(a_hit_in_range, clk, arst_n,
		res_valid && hit_q, idx_q <= last_eff)

endmodule
